@@ rtl/url_pct_pkg.sv @@
// ----------------------------------------------------------------------------
// url_pct_pkg
// Shared types, character constants and helper functions for the URL
// percent codec.
// ----------------------------------------------------------------------------
package url_pct_pkg;

   localparam logic [7:0] CH_PERCENT = 8'h25;
   localparam logic [7:0] CH_PLUS    = 8'h2B;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_DASH    = 8'h2D;
   localparam logic [7:0] CH_UNDER   = 8'h5F;
   localparam logic [7:0] CH_DOT     = 8'h2E;
   localparam logic [7:0] CH_TILDE   = 8'h7E;
   localparam logic [7:0] CH_0       = 8'h30;
   localparam logic [7:0] CH_9       = 8'h39;
   localparam logic [7:0] CH_UA      = 8'h41;
   localparam logic [7:0] CH_UF      = 8'h46;
   localparam logic [7:0] CH_UZ      = 8'h5A;
   localparam logic [7:0] CH_LA      = 8'h61;
   localparam logic [7:0] CH_LF      = 8'h66;
   localparam logic [7:0] CH_LZ      = 8'h7A;

   localparam logic [1:0] PHASE_IDLE  = 2'd0;
   localparam logic [1:0] PHASE_PCT   = 2'd1;
   localparam logic [1:0] PHASE_DIGIT = 2'd2;

   localparam logic CSR_DIRECTION      = 1'b0;
   localparam logic CSR_PLUS_FOR_SPACE = 1'b1;

   localparam logic DIR_ENCODE = 1'b0;

   typedef struct packed {
      logic [2:0][7:0] slots;
      logic [1:0]      count;
      logic            eom;
   } job_type;

   function automatic logic is_unreserved(input logic [7:0] c);
      is_unreserved = (c >= CH_0 && c <= CH_9) || (c >= CH_UA && c <= CH_UZ) ||
                      (c >= CH_LA && c <= CH_LZ) || c == CH_DASH ||
                      c == CH_UNDER || c == CH_DOT || c == CH_TILDE;
   endfunction

   // bit 4 set: not a hex digit
   function automatic logic [4:0] hex_value(input logic [7:0] c);
      logic [7:0] d;
      begin
         d = 8'd0;
         if (c >= CH_0 && c <= CH_9) begin
            d = c - CH_0;
         end else if (c >= CH_UA && c <= CH_UF) begin
            d = c - CH_UA + 8'd10;
         end else if (c >= CH_LA && c <= CH_LF) begin
            d = c - CH_LA + 8'd10;
         end else begin
            d = 8'd16;
         end
         hex_value = d[4:0];
      end
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] n);
      if (n < 4'd10) begin
         hex_char = CH_0 + {4'd0, n};
      end else begin
         hex_char = CH_UA + {4'd0, n} - 8'd10;
      end
   endfunction

endpackage

@@ rtl/url_pct_queue.sv @@
// ----------------------------------------------------------------------------
// url_pct_queue
// Small job queue between the classifying front end and the output
// sequencer.
// ----------------------------------------------------------------------------
module url_pct_queue
   import url_pct_pkg::*;
#(
   parameter int DEPTH = 4
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   output logic    full,
   input  logic    pop,
   output job_type pop_job,
   output logic    empty
);

   localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntW = $clog2(DEPTH + 1);

   job_type         entry_ff [DEPTH];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff,  count_in;
   logic            do_push, do_pop;

   assign full    = (count_ff == CntW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign pop_job = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

@@ rtl/url_pct_front.sv @@
// ----------------------------------------------------------------------------
// url_pct_front
// Accepts requests, holds the configuration and the escape state, and turns
// each request into a job of zero to three output bytes.
// ----------------------------------------------------------------------------
module url_pct_front
   import url_pct_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_write_enable,
   input  logic       csr_index,
   input  logic       csr_write_data,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_data_byte,
   input  logic       req_end_of_message,
   input  logic       queue_full,
   output logic       push,
   output job_type    push_job
);

   logic       direction_ff, direction_in;
   logic       plus_ff,      plus_in;
   logic [1:0] phase_ff,     phase_in;
   logic [7:0] held_ff,      held_in;
   logic       accept;
   job_type    job;
   logic [7:0] c;
   logic [7:0] plain;
   logic [4:0] hi;
   logic [4:0] lo;

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;
   assign c         = req_data_byte;
   assign plain     = (plus_ff && c == CH_PLUS) ? CH_SPACE : c;
   assign hi        = hex_value(held_ff);
   assign lo        = hex_value(c);

   always_comb begin
      direction_in = direction_ff;
      plus_in      = plus_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_DIRECTION:      direction_in = csr_write_data;
            CSR_PLUS_FOR_SPACE: plus_in      = csr_write_data;
            default:            ;
         endcase
      end
   end

   always_comb begin
      job.slots = '0;
      job.count = 2'd0;
      job.eom   = req_end_of_message;
      phase_in  = PHASE_IDLE;
      held_in   = held_ff;
      if (direction_ff == DIR_ENCODE) begin
         if (plus_ff && c == CH_SPACE) begin
            job.slots[0] = CH_PLUS;
            job.count    = 2'd1;
         end else if (is_unreserved(c)) begin
            job.slots[0] = c;
            job.count    = 2'd1;
         end else begin
            job.slots[0] = CH_PERCENT;
            job.slots[1] = hex_char(c[7:4]);
            job.slots[2] = hex_char(c[3:0]);
            job.count    = 2'd3;
         end
      end else begin
         case (phase_ff)
            PHASE_PCT: begin
               if (req_end_of_message) begin
                  job.slots[0] = CH_PERCENT;
                  job.slots[1] = plain;
                  job.count    = 2'd2;
               end else begin
                  held_in  = c;
                  phase_in = PHASE_DIGIT;
               end
            end
            PHASE_DIGIT: begin
               if (hi[4]) begin
                  job.slots[0] = 8'd0;
               end else if (lo[4]) begin
                  job.slots[0] = {4'd0, hi[3:0]};
               end else begin
                  job.slots[0] = {hi[3:0], lo[3:0]};
               end
               job.count = 2'd1;
            end
            default: begin
               if (c == CH_PERCENT) begin
                  if (req_end_of_message) begin
                     job.slots[0] = CH_PERCENT;
                     job.count    = 2'd1;
                  end else begin
                     phase_in = PHASE_PCT;
                  end
               end else begin
                  job.slots[0] = plain;
                  job.count    = 2'd1;
               end
            end
         endcase
      end
      if (req_end_of_message) begin
         phase_in = PHASE_IDLE;
      end
   end

   assign push     = accept && (job.count != 2'd0);
   assign push_job = job;

   always_ff @(posedge clock) begin
      if (reset) begin
         direction_ff <= 1'b0;
         plus_ff      <= 1'b0;
         phase_ff     <= PHASE_IDLE;
         held_ff      <= 8'd0;
      end else begin
         direction_ff <= direction_in;
         plus_ff      <= plus_in;
         if (accept) begin
            phase_ff <= phase_in;
            held_ff  <= held_in;
         end
      end
   end

endmodule

@@ rtl/url_pct_back.sv @@
// ----------------------------------------------------------------------------
// url_pct_back
// Takes jobs from the queue and sends their bytes one per cycle, while
// rsp_ready allows, through a registered response stage.
// ----------------------------------------------------------------------------
module url_pct_back
   import url_pct_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       queue_empty,
   input  job_type    queue_job,
   output logic       pop,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_run_last,
   output logic       rsp_message_end
);

   job_type    job_ff;
   logic       job_valid_ff, job_valid_in;
   logic [1:0] pos_ff, pos_in;
   logic       out_valid_ff, out_valid_in;
   logic [7:0] out_byte_ff;
   logic       out_last_ff;
   logic       out_end_ff;
   logic       load_out;
   logic       emit;
   logic       last;

   assign load_out = !out_valid_ff || rsp_ready;
   assign emit     = job_valid_ff && load_out;
   assign last     = (pos_ff == job_ff.count - 2'd1);
   assign pop      = !queue_empty && (!job_valid_ff || (emit && last));

   always_comb begin
      job_valid_in = job_valid_ff;
      pos_in       = pos_ff;
      out_valid_in = out_valid_ff;
      if (load_out) begin
         out_valid_in = emit;
      end
      if (emit) begin
         if (last) begin
            job_valid_in = 1'b0;
         end else begin
            pos_in = pos_ff + 2'd1;
         end
      end
      if (pop) begin
         job_valid_in = 1'b1;
         pos_in       = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         job_valid_ff <= 1'b0;
         pos_ff       <= 2'd0;
         out_valid_ff <= 1'b0;
      end else begin
         job_valid_ff <= job_valid_in;
         pos_ff       <= pos_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         job_ff <= queue_job;
      end
      if (emit) begin
         out_byte_ff <= job_ff.slots[pos_ff];
         out_last_ff <= last;
         out_end_ff  <= last && job_ff.eom;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_out_byte    = out_byte_ff;
   assign rsp_run_last    = out_last_ff;
   assign rsp_message_end = out_end_ff;

endmodule

@@ rtl/url_percent_codec.sv @@
// ----------------------------------------------------------------------------
// url_percent_codec
// Byte-stream URL percent encoder and decoder.
// ----------------------------------------------------------------------------
// Each request carries one message byte and produces one to three response
// bytes in encode mode, and zero to two in decode mode. The response side
// sends one byte per cycle while rsp_ready allows it: a byte that passes
// yields one response byte, an escaped byte three. Requests are classified
// on entry and queued as jobs (QUEUE_DEPTH entries), so requests keep
// arriving while escapes drain until the queue is full; a request that
// yields no byte queues no job. From request to first response byte the
// data passes the queue entry, the job register and the output register.
module url_percent_codec
   import url_pct_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_write_enable,
   input  logic       csr_index,
   input  logic       csr_write_data,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_data_byte,
   input  logic       req_end_of_message,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_run_last,
   output logic       rsp_message_end
);

   logic    push;
   job_type push_job;
   logic    queue_full;
   logic    pop;
   job_type pop_job;
   logic    queue_empty;

   url_pct_front u_front (
      .clock              (clock),
      .reset              (reset),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_data_byte      (req_data_byte),
      .req_end_of_message (req_end_of_message),
      .queue_full         (queue_full),
      .push               (push),
      .push_job           (push_job)
   );

   url_pct_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .full     (queue_full),
      .pop      (pop),
      .pop_job  (pop_job),
      .empty    (queue_empty)
   );

   url_pct_back u_back (
      .clock           (clock),
      .reset           (reset),
      .queue_empty     (queue_empty),
      .queue_job       (pop_job),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_run_last    (rsp_run_last),
      .rsp_message_end (rsp_message_end)
   );

endmodule
